// File: rtl/tlec_pkg.sv
`default_nettype none
package tlec_pkg;

  localparam int DEF_L1_LINES  = 256;
  localparam int DEF_L2_LINES  = 1024;
  localparam int DEF_ADDR_BITS = 32;

  // Widest set number that the 4-bit index registers can produce.
  localparam int SET_W      = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_INDEX_BITS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_WAYS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_INDEX_BITS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_WAYS       = 3'd4;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam logic [1:0] L1_RD_HIT  = 2'd0;
  localparam logic [1:0] L1_RD_MISS = 2'd1;
  localparam logic [1:0] L1_WR_HIT  = 2'd2;
  localparam logic [1:0] L1_WR_MISS = 2'd3;

  localparam logic [2:0] L2_NONE    = 3'd0;
  localparam logic [2:0] L2_RD_HIT  = 3'd1;
  localparam logic [2:0] L2_RD_MISS = 3'd2;
  localparam logic [2:0] L2_WR_HIT  = 3'd3;
  localparam logic [2:0] L2_WR_MISS = 3'd4;

  typedef struct packed {
    logic        func;
    logic [31:0] addr;
  } in_t;

  typedef struct packed {
    logic [1:0] l1_status;
    logic [2:0] l2_status;
    logic       mem_status;
  } out_t;

  typedef struct packed {
    logic       clr;
    logic       load;
    logic       split;
    logic       lvl;
    logic       divq;
    logic       divr;
    logic       mul;
    logic       scan;
    logic       wr_hit1;
    logic       wr_hit2;
    logic       inv2;
    logic       fill1;
    logic       fill2;
    logic       ptr_wr;
    logic       repl1;
    logic       repl2;
    logic       res_we;
    logic [1:0] s1;
    logic [2:0] s2;
    logic       mem;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_busy;
    logic scan_busy;
    logic func;
    logic hit1;
    logic free1;
    logic hit2;
    logic free2;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/tlec_ram.sv
`default_nettype none
module tlec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: rtl/tlec_div.sv
`default_nettype none
module tlec_div #(
  parameter int W = 17
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              busy,
  output logic      [W-1:0] quot,
  output logic      [W-1:0] rem
);

  localparam int CNTW = $clog2(W + 1);

  logic [CNTW-1:0] cnt_r;
  logic [W:0]      rem_r;
  logic [W-1:0]    quo_r;
  logic [W-1:0]    dsor_r;
  logic [W:0]      shifted;
  logic            ge;

  // Restoring division, one quotient bit per cycle. The divisor is held for
  // the whole run, since the caller may feed it from the quotient register.
  assign shifted = {rem_r[W-1:0], quo_r[W-1]};
  assign ge      = shifted >= {1'b0, dsor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r  <= CNTW'(W);
      rem_r  <= '0;
      quo_r  <= dividend;
      dsor_r <= divisor;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CNTW'(1);
      rem_r <= ge ? (shifted - {1'b0, dsor_r}) : shifted;
      quo_r <= {quo_r[W-2:0], ge};
    end
  end

  assign busy = cnt_r != '0;
  assign quot = quo_r;
  assign rem  = rem_r[W-1:0];

endmodule
`default_nettype wire

// File: rtl/tlec_ctrl.sv
`default_nettype none
module tlec_ctrl
  import tlec_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SPLIT = 4'd2;
  localparam logic [3:0] S_LQ    = 4'd3;
  localparam logic [3:0] S_LQW   = 4'd4;
  localparam logic [3:0] S_LR    = 4'd5;
  localparam logic [3:0] S_LRW   = 4'd6;
  localparam logic [3:0] S_LM    = 4'd7;
  localparam logic [3:0] S_SCAN  = 4'd8;
  localparam logic [3:0] S_SCANW = 4'd9;
  localparam logic [3:0] S_DEC   = 4'd10;
  localparam logic [3:0] S_PTRR  = 4'd11;
  localparam logic [3:0] S_PTRW  = 4'd12;
  localparam logic [3:0] S_REPL  = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  // Phase of the transaction: which lookup the shared locate and scan
  // hardware is working on.
  localparam logic [2:0] PH_A1 = 3'd0;
  localparam logic [2:0] PH_A2 = 3'd1;
  localparam logic [2:0] PH_S1 = 3'd2;
  localparam logic [2:0] PH_S2 = 3'd3;
  localparam logic [2:0] PH_V  = 3'd4;
  localparam logic [2:0] PH_SV = 3'd5;

  logic [3:0] state_r, state_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic       lvl_ls;
  logic       lvl_ptr;

  assign lvl_ls  = !(phase_r == PH_A1 || phase_r == PH_S1);
  assign lvl_ptr = phase_r == PH_SV;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    phase_nxt = phase_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        cmd.split = 1'b1;
        phase_nxt = PH_A1;
        state_nxt = S_LQ;
      end
      S_LQ: begin
        cmd.lvl   = lvl_ls;
        cmd.divq  = 1'b1;
        state_nxt = S_LQW;
      end
      S_LQW: begin
        cmd.lvl = lvl_ls;
        if (!sts.div_busy) state_nxt = S_LR;
      end
      S_LR: begin
        cmd.lvl   = lvl_ls;
        cmd.divr  = 1'b1;
        state_nxt = S_LRW;
      end
      S_LRW: begin
        cmd.lvl = lvl_ls;
        if (!sts.div_busy) state_nxt = S_LM;
      end
      S_LM: begin
        cmd.lvl = lvl_ls;
        cmd.mul = 1'b1;
        if (phase_r == PH_A1) begin
          phase_nxt = PH_A2;
          state_nxt = S_LQ;
        end else if (phase_r == PH_A2) begin
          phase_nxt = PH_S1;
          state_nxt = S_SCAN;
        end else begin
          phase_nxt = PH_SV;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.lvl   = lvl_ls;
        cmd.scan  = 1'b1;
        state_nxt = S_SCANW;
      end
      S_SCANW: begin
        if (!sts.scan_busy) state_nxt = S_DEC;
      end
      S_DEC: begin
        if (phase_r == PH_S1) begin
          if (sts.hit1) begin
            cmd.res_we  = 1'b1;
            cmd.s1      = (sts.func == FUNC_WRITE) ? L1_WR_HIT : L1_RD_HIT;
            cmd.s2      = L2_NONE;
            cmd.wr_hit1 = sts.func == FUNC_WRITE;
            state_nxt   = S_OUT;
          end else begin
            phase_nxt = PH_S2;
            state_nxt = S_SCAN;
          end
        end else if (phase_r == PH_S2) begin
          cmd.res_we = 1'b1;
          if (sts.func == FUNC_WRITE) begin
            cmd.s1      = L1_WR_MISS;
            cmd.s2      = sts.hit2 ? L2_WR_HIT : L2_WR_MISS;
            cmd.mem     = !sts.hit2;
            cmd.wr_hit2 = sts.hit2;
            state_nxt   = S_OUT;
          end else begin
            cmd.s1   = L1_RD_MISS;
            cmd.s2   = sts.hit2 ? L2_RD_HIT : L2_RD_MISS;
            cmd.inv2 = sts.hit2;
            if (sts.free1) begin
              cmd.fill1 = 1'b1;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_PTRR;
            end
          end
        end else begin
          if (sts.free2) begin
            cmd.fill2 = 1'b1;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_PTRR;
          end
        end
      end
      S_PTRR: begin
        cmd.lvl   = lvl_ptr;
        state_nxt = S_PTRW;
      end
      S_PTRW: begin
        cmd.lvl    = lvl_ptr;
        cmd.ptr_wr = 1'b1;
        state_nxt  = S_REPL;
      end
      S_REPL: begin
        cmd.lvl = lvl_ptr;
        if (lvl_ptr) begin
          cmd.repl2 = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.repl1 = 1'b1;
          phase_nxt = PH_V;
          state_nxt = S_LQ;
        end
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      phase_r <= PH_A1;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = state_r == S_OUT;

endmodule
`default_nettype wire

// File: rtl/tlec_dp.sv
`default_nettype none
module tlec_dp
  import tlec_pkg::*;
#(
  parameter int L1_LINES  = DEF_L1_LINES,
  parameter int L2_LINES  = DEF_L2_LINES,
  parameter int ADDR_BITS = DEF_ADDR_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire in_t                   in_data,
  output out_t                       out_data,
  input  wire cmd_t                  cmd,
  output sts_t                       sts
);

  localparam int A1   = (L1_LINES > 1) ? $clog2(L1_LINES) : 1;
  localparam int A2   = (L2_LINES > 1) ? $clog2(L2_LINES) : 1;
  localparam int AM   = (A1 > A2) ? A1 : A2;
  localparam int CW1  = $clog2(L1_LINES + 1);
  localparam int CW2  = $clog2(L2_LINES + 1);
  localparam int CWM  = (CW1 > CW2) ? CW1 : CW2;
  localparam int DW   = (CWM > SET_W) ? CWM : SET_W;
  localparam int SUMW = ((AM > CWM) ? AM : CWM) + 1;
  localparam int NM   = (L1_LINES > L2_LINES) ? L1_LINES : L2_LINES;
  localparam int CLRW = (NM > 1) ? $clog2(NM) : 1;
  localparam int LW   = ADDR_BITS + 2;

  // Configuration registers.
  logic [3:0]  off_r, ib1_r, ib2_r;
  logic [8:0]  w1_r;
  logic [10:0] w2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= 4'd5;
      ib1_r <= 4'd6;
      w1_r  <= 9'd4;
      ib2_r <= 4'd8;
      w2_r  <= 11'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFFSET_BITS:   off_r <= cfg_wdata[3:0];
        CFG_L1_INDEX_BITS: ib1_r <= cfg_wdata[3:0];
        CFG_L1_WAYS:       w1_r  <= cfg_wdata[8:0];
        CFG_L2_INDEX_BITS: ib2_r <= cfg_wdata[3:0];
        CFG_L2_WAYS:       w2_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective associativity: zero acts as one, and it never exceeds the lines.
  logic [CWM-1:0] ways1, ways2, ways_l;
  assign ways1 = (w1_r == '0) ? CWM'(1) :
                 ((32'(w1_r) > 32'(L1_LINES)) ? CWM'(L1_LINES) : CWM'(w1_r));
  assign ways2 = (w2_r == '0) ? CWM'(1) :
                 ((32'(w2_r) > 32'(L2_LINES)) ? CWM'(L2_LINES) : CWM'(w2_r));
  assign ways_l = cmd.lvl ? ways2 : ways1;

  // Transaction registers.
  logic                 func_r;
  logic [ADDR_BITS-1:0] addr_r, tag1_r, tag2_r;
  logic [SET_W-1:0]     set1_r, set2_r;
  logic                 vd_r;
  logic [1:0]           s1_r;
  logic [2:0]           s2_r;
  logic                 mem_r;

  logic [SET_W:0]       m1_full, m2_full;
  logic [SET_W-1:0]     mask1, mask2;
  logic [4:0]           sh1, sh2;
  logic [ADDR_BITS:0]   om_full;
  logic [ADDR_BITS-1:0] vtag, vaddr;

  assign m1_full = ((SET_W+1)'(1) << ib1_r) - (SET_W+1)'(1);
  assign m2_full = ((SET_W+1)'(1) << ib2_r) - (SET_W+1)'(1);
  assign mask1   = m1_full[SET_W-1:0];
  assign mask2   = m2_full[SET_W-1:0];
  assign sh1     = {1'b0, off_r} + {1'b0, ib1_r};
  assign sh2     = {1'b0, off_r} + {1'b0, ib2_r};
  assign om_full = ((ADDR_BITS+1)'(1) << off_r) - (ADDR_BITS+1)'(1);

  // Line RAM read data.
  logic [LW-1:0] rd1, rd2;

  // The L1 victim's address is rebuilt from its tag, the L1 set of this
  // access and this access's offset, then split with the L2 geometry.
  assign vtag  = rd1[LW-1:2];
  assign vaddr = (((vtag << ib1_r) | ADDR_BITS'(set1_r)) << off_r)
                 | (addr_r & om_full[ADDR_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_data.func;
      addr_r <= ADDR_BITS'({32'd0, in_data.addr});
    end
    if (cmd.split) begin
      tag1_r <= addr_r >> sh1;
      set1_r <= SET_W'(addr_r >> off_r) & mask1;
      tag2_r <= addr_r >> sh2;
      set2_r <= SET_W'(addr_r >> off_r) & mask2;
    end else if (cmd.repl1) begin
      vd_r   <= rd1[0];
      tag2_r <= vaddr >> sh2;
      set2_r <= SET_W'(vaddr >> off_r) & mask2;
    end
    if (cmd.res_we) begin
      s1_r  <= cmd.s1;
      s2_r  <= cmd.s2;
      mem_r <= cmd.mem;
    end else if (cmd.repl2) begin
      mem_r <= 1'b1;
    end
  end

  // Locate: rows = lines / ways, row = set % rows, base = row * ways.
  logic            div_start, div_busy;
  logic [DW-1:0]   div_dend, div_dsor, div_quot, div_rem;
  logic [DW-1:0]   cap_l, set_l;
  logic [2*CWM-1:0] prod;
  logic [A1-1:0]   slot1_r, base1_r;
  logic [A2-1:0]   slot2_r, base2_r;

  assign cap_l     = cmd.lvl ? DW'(L2_LINES) : DW'(L1_LINES);
  assign set_l     = cmd.lvl ? DW'(set2_r) : DW'(set1_r);
  assign div_start = cmd.divq | cmd.divr;
  assign div_dend  = cmd.divq ? cap_l : set_l;
  assign div_dsor  = cmd.divq ? DW'(ways_l) : div_quot;
  assign prod      = CWM'(div_rem) * ways_l;

  tlec_div #(.W(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dend),
    .divisor  (div_dsor),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      if (cmd.lvl) begin
        slot2_r <= A2'(div_rem);
        base2_r <= A2'(prod);
      end else begin
        slot1_r <= A1'(div_rem);
        base1_r <= A1'(prod);
      end
    end
  end

  // Way scan: one RAM read issued per cycle, checked in the cycle after.
  logic            sc_run_r, sc_chk_r, sc_lvl_r;
  logic [CWM-1:0]  sc_iss_r;
  logic [AM-1:0]   sc_idx_r;
  logic [CWM-1:0]  sc_ways;
  logic [AM-1:0]   sc_base, sc_addr;
  logic [SUMW-1:0] sc_sum;
  logic            sc_more;
  logic [LW-1:0]   sc_line;
  logic            sc_valid;

  logic          hit1_r, free1_r, hit2_r, hit2_d_r, free2_r;
  logic [A1-1:0] hit1_idx_r, free1_idx_r;
  logic [A2-1:0] hit2_idx_r, free2_idx_r;

  assign sc_ways  = sc_lvl_r ? ways2 : ways1;
  assign sc_base  = sc_lvl_r ? AM'(base2_r) : AM'(base1_r);
  assign sc_sum   = SUMW'(sc_base) + SUMW'(sc_iss_r);
  assign sc_addr  = sc_sum[AM-1:0];
  assign sc_more  = sc_iss_r < sc_ways;
  assign sc_line  = sc_lvl_r ? rd2 : rd1;
  assign sc_valid = sc_line[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_run_r <= 1'b0;
      sc_chk_r <= 1'b0;
    end else if (cmd.scan) begin
      sc_run_r <= 1'b1;
      sc_chk_r <= 1'b0;
    end else if (sc_run_r) begin
      sc_chk_r <= sc_more;
      if (!sc_more && !sc_chk_r) sc_run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      sc_lvl_r <= cmd.lvl;
      sc_iss_r <= '0;
      if (cmd.lvl) begin
        hit2_r  <= 1'b0;
        free2_r <= 1'b0;
      end else begin
        hit1_r  <= 1'b0;
        free1_r <= 1'b0;
      end
    end else if (sc_run_r) begin
      if (sc_more) begin
        sc_iss_r <= sc_iss_r + CWM'(1);
        sc_idx_r <= sc_addr;
      end
      if (sc_chk_r) begin
        if (sc_lvl_r) begin
          if (sc_valid && sc_line[LW-1:2] == tag2_r && !hit2_r) begin
            hit2_r     <= 1'b1;
            hit2_idx_r <= A2'(sc_idx_r);
            hit2_d_r   <= sc_line[0];
          end
          if (!sc_valid && !free2_r) begin
            free2_r     <= 1'b1;
            free2_idx_r <= A2'(sc_idx_r);
          end
        end else begin
          if (sc_valid && sc_line[LW-1:2] == tag1_r && !hit1_r) begin
            hit1_r     <= 1'b1;
            hit1_idx_r <= A1'(sc_idx_r);
          end
          if (!sc_valid && !free1_r) begin
            free1_r     <= 1'b1;
            free1_idx_r <= A1'(sc_idx_r);
          end
        end
      end
    end
  end

  // Round-robin pointer; a pointer at or beyond the current way count restarts at 0.
  logic [A1-1:0]   prd1;
  logic [A2-1:0]   prd2;
  logic [AM-1:0]   ptr_l, pos, base_l, vic_addr;
  logic [SUMW-1:0] pos_inc, vic_sum;
  logic [AM-1:0]   ptr_nxt;
  logic [AM-1:0]   vidx_r;

  assign ptr_l    = cmd.lvl ? AM'(prd2) : AM'(prd1);
  assign pos      = (SUMW'(ptr_l) >= SUMW'(ways_l)) ? '0 : ptr_l;
  assign pos_inc  = SUMW'(pos) + SUMW'(1);
  assign ptr_nxt  = (pos_inc >= SUMW'(ways_l)) ? '0 : pos_inc[AM-1:0];
  assign base_l   = cmd.lvl ? AM'(base2_r) : AM'(base1_r);
  assign vic_sum  = SUMW'(base_l) + SUMW'(pos);
  assign vic_addr = vic_sum[AM-1:0];

  always_ff @(posedge clk) begin
    if (cmd.ptr_wr) vidx_r <= vic_addr;
  end

  // Clearing pass after reset.
  logic [CLRW-1:0] clr_cnt_r;
  logic            clr1, clr2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr) begin
      clr_cnt_r <= clr_cnt_r + CLRW'(1);
    end
  end

  assign clr1 = 32'(clr_cnt_r) < 32'(L1_LINES);
  assign clr2 = 32'(clr_cnt_r) < 32'(L2_LINES);

  // A line that moves into L1 carries the dirty mark of its L2 copy.
  logic d_mv;
  assign d_mv = hit2_r & hit2_d_r;

  logic          l1_we, l2_we, p1_we, p2_we;
  logic [A1-1:0] l1_waddr, l1_raddr, p1_waddr;
  logic [A2-1:0] l2_waddr, l2_raddr, p2_waddr;
  logic [LW-1:0] l1_wdata, l2_wdata;
  logic [A1-1:0] p1_wdata;
  logic [A2-1:0] p2_wdata;

  always_comb begin
    l1_we    = 1'b0;
    l1_waddr = hit1_idx_r;
    l1_wdata = {tag1_r, 1'b1, 1'b1};
    priority if (cmd.clr) begin
      l1_we    = clr1;
      l1_waddr = A1'(clr_cnt_r);
      l1_wdata = '0;
    end else if (cmd.wr_hit1) begin
      l1_we = 1'b1;
    end else if (cmd.fill1) begin
      l1_we    = 1'b1;
      l1_waddr = free1_idx_r;
      l1_wdata = {tag1_r, 1'b1, d_mv};
    end else if (cmd.repl1) begin
      l1_we    = 1'b1;
      l1_waddr = A1'(vidx_r);
      l1_wdata = {tag1_r, 1'b1, d_mv};
    end else begin
      l1_we = 1'b0;
    end
  end

  always_comb begin
    l2_we    = 1'b0;
    l2_waddr = hit2_idx_r;
    l2_wdata = {tag2_r, 1'b1, 1'b1};
    priority if (cmd.clr) begin
      l2_we    = clr2;
      l2_waddr = A2'(clr_cnt_r);
      l2_wdata = '0;
    end else if (cmd.wr_hit2) begin
      l2_we = 1'b1;
    end else if (cmd.inv2) begin
      l2_we    = 1'b1;
      l2_wdata = '0;
    end else if (cmd.fill2) begin
      l2_we    = 1'b1;
      l2_waddr = free2_idx_r;
      l2_wdata = {tag2_r, 1'b1, vd_r};
    end else if (cmd.repl2) begin
      l2_we    = 1'b1;
      l2_waddr = A2'(vidx_r);
      l2_wdata = {tag2_r, 1'b1, vd_r};
    end else begin
      l2_we = 1'b0;
    end
  end

  assign p1_we    = cmd.clr ? clr1 : (cmd.ptr_wr && !cmd.lvl);
  assign p1_waddr = cmd.clr ? A1'(clr_cnt_r) : slot1_r;
  assign p1_wdata = cmd.clr ? '0 : A1'(ptr_nxt);
  assign p2_we    = cmd.clr ? clr2 : (cmd.ptr_wr && cmd.lvl);
  assign p2_waddr = cmd.clr ? A2'(clr_cnt_r) : slot2_r;
  assign p2_wdata = cmd.clr ? '0 : A2'(ptr_nxt);

  assign l1_raddr = cmd.ptr_wr ? A1'(vic_addr) : A1'(sc_addr);
  assign l2_raddr = cmd.ptr_wr ? A2'(vic_addr) : A2'(sc_addr);

  tlec_ram #(.WIDTH(LW), .DEPTH(L1_LINES)) u_l1_lines (
    .clk (clk), .we (l1_we), .waddr (l1_waddr), .wdata (l1_wdata),
    .raddr (l1_raddr), .rdata (rd1)
  );

  tlec_ram #(.WIDTH(LW), .DEPTH(L2_LINES)) u_l2_lines (
    .clk (clk), .we (l2_we), .waddr (l2_waddr), .wdata (l2_wdata),
    .raddr (l2_raddr), .rdata (rd2)
  );

  tlec_ram #(.WIDTH(A1), .DEPTH(L1_LINES)) u_l1_ptr (
    .clk (clk), .we (p1_we), .waddr (p1_waddr), .wdata (p1_wdata),
    .raddr (slot1_r), .rdata (prd1)
  );

  tlec_ram #(.WIDTH(A2), .DEPTH(L2_LINES)) u_l2_ptr (
    .clk (clk), .we (p2_we), .waddr (p2_waddr), .wdata (p2_wdata),
    .raddr (slot2_r), .rdata (prd2)
  );

  assign out_data.l1_status  = s1_r;
  assign out_data.l2_status  = s2_r;
  assign out_data.mem_status = mem_r;

  assign sts.clr_last  = clr_cnt_r == CLRW'(NM - 1);
  assign sts.div_busy  = div_busy;
  assign sts.scan_busy = sc_run_r;
  assign sts.func      = func_r;
  assign sts.hit1      = hit1_r;
  assign sts.free1     = free1_r;
  assign sts.hit2      = hit2_r;
  assign sts.free2     = free2_r;

endmodule
`default_nettype wire

// File: rtl/two_level_exclusive_cache_tags_top.sv
`default_nettype none
// Tag model of a two-level exclusive cache with round-robin replacement per
// set: each transaction is a read or write address, and one status result
// (L1 status, L2 status, memory write flag) comes back per transaction. The
// block handles one transaction at a time. After reset it runs a clearing
// pass over the tag and pointer RAMs before it takes its first transaction;
// configuration writes are taken during that pass. Each transaction locates
// its L1 and L2 sets with the divider, which is DW bits wide (15 at the
// defaults), then searches the L1 set and, on an L1 miss, the L2 set; an L1
// hit skips the L2 search. A read miss that evicts from L1 then locates and
// searches the L2 set of the victim, and when that L2 set is full it also
// replaces an L2 line. The next transaction is taken in the cycle after the
// result leaves. Most of the time is spent in the bit-serial divider that
// maps set numbers onto storage rows and in the tag search, which reads one
// way per cycle from a single RAM port.
module two_level_exclusive_cache_tags_top
  import tlec_pkg::*;
#(
  parameter int L1_LINES  = DEF_L1_LINES,
  parameter int L2_LINES  = DEF_L2_LINES,
  parameter int ADDR_BITS = DEF_ADDR_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_t                       out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  tlec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tlec_dp #(
    .L1_LINES  (L1_LINES),
    .L2_LINES  (L2_LINES),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire
